// ----- hdl/sact_pkg.sv -----
// Shared types and constants of the set-associative cache tag controller.
// No dependencies.
package sact_pkg;

    // Replacement policy codes
    localparam logic [1:0] POL_LRU  = 2'd0;
    localparam logic [1:0] POL_FIFO = 2'd1;

    // Register indexes of the configuration port
    localparam logic [1:0] REG_WAYS  = 2'd0;
    localparam logic [1:0] REG_WT    = 2'd1;
    localparam logic [1:0] REG_WA    = 2'd2;
    localparam logic [1:0] REG_POL   = 2'd3;

    typedef struct packed {
        logic [31:0] address;
        logic [6:0]  size_bytes;
        logic        is_read;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic        crosses_block;
        logic        lower_access;
        logic        fill;
        logic        writeback;
        logic [31:0] writeback_address;
    } rsp_t;

    typedef struct packed {
        logic [3:0] ways_in_use;
        logic       write_through_mode;
        logic       write_allocate_mode;
        logic [1:0] replace_policy;
    } cfg_t;

endpackage

// ----- hdl/sact_mem.sv -----
// Set metadata memory: one row per set, one write and one registered read port.
// Depends on nothing.
module sact_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 204
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/sact_upd.sv -----
// Tag compare, policy and replacement logic for one set row.
// Depends on sact_pkg.
module sact_upd #(
    parameter int INDEX_BITS  = 6,
    parameter int OFFSET_BITS = 6,
    parameter int MAX_WAYS    = 8,
    parameter int TAG_W       = 20,
    parameter int RK_W        = 3,
    parameter int CN_W        = 4,
    parameter int SI_W        = 6
) (
    input  sact_pkg::req_t                       req,
    input  sact_pkg::cfg_t                       cfg,
    input  logic [SI_W-1:0]                      set_idx,
    input  logic [MAX_WAYS-1:0][TAG_W-1:0]       tag_in,
    input  logic [MAX_WAYS-1:0][RK_W-1:0]        rank_in,
    input  logic [MAX_WAYS-1:0]                  valid_in,
    input  logic [MAX_WAYS-1:0]                  dirty_in,
    input  logic [CN_W-1:0]                      cnt_in,
    output logic [MAX_WAYS-1:0][TAG_W-1:0]       tag_out,
    output logic [MAX_WAYS-1:0][RK_W-1:0]        rank_out,
    output logic [MAX_WAYS-1:0]                  valid_out,
    output logic [MAX_WAYS-1:0]                  dirty_out,
    output logic [CN_W-1:0]                      cnt_out,
    output logic                                 row_we,
    output sact_pkg::rsp_t                       rsp
);
    import sact_pkg::*;

    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

    logic [TAG_W-1:0]       tag;
    logic [OFFSET_BITS-1:0] offset;
    logic                   crosses;
    logic [4:0]             ways_eff;
    logic                   found;
    logic [WAY_W-1:0]       hway;
    logic [WAY_W-1:0]       free_way;
    logic [WAY_W-1:0]       old_way;
    logic [WAY_W-1:0]       mk_way;
    logic                   do_mk;
    logic [RK_W-1:0]        r;
    logic [4:0]             top;

    assign tag     = req.address[31 -: TAG_W];
    assign offset  = req.address[OFFSET_BITS-1:0];
    assign crosses = (32'(offset) + 32'(req.size_bytes)) > (32'd1 << OFFSET_BITS);

    // Clamp the associativity to 1..MAX_WAYS
    always_comb
    begin
        if (cfg.ways_in_use == 4'd0)
            ways_eff = 5'd1;
        else if (5'(cfg.ways_in_use) > 5'(MAX_WAYS))
            ways_eff = 5'(MAX_WAYS);
        else
            ways_eff = 5'(cfg.ways_in_use);
    end

    // Search ways: lowest index wins
    always_comb
    begin
        found    = 1'b0;
        hway     = '0;
        free_way = '0;
        old_way  = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (valid_in[w] && tag_in[w] == tag)
            begin
                found = 1'b1;
                hway  = WAY_W'(w);
            end
            if (!valid_in[w])
                free_way = WAY_W'(w);
            if (valid_in[w] && rank_in[w] == '0)
                old_way = WAY_W'(w);
        end
    end

    // Decide result and new row contents
    always_comb
    begin
        tag_out   = tag_in;
        rank_out  = rank_in;
        valid_out = valid_in;
        dirty_out = dirty_in;
        cnt_out   = cnt_in;
        row_we    = 1'b0;
        rsp       = '0;
        do_mk     = 1'b0;
        mk_way    = hway;
        if (crosses)
        begin
            rsp.crosses_block = 1'b1;
        end
        else if (found)
        begin
            rsp.hit = 1'b1;
            row_we  = 1'b1;
            if (!req.is_read)
            begin
                if (cfg.write_through_mode)
                    rsp.lower_access = 1'b1;
                else
                    dirty_out[hway] = 1'b1;
            end
            do_mk = (cfg.replace_policy == POL_LRU);
        end
        else
        begin
            rsp.lower_access = 1'b1;
            if (req.is_read || cfg.write_allocate_mode)
            begin
                rsp.fill = 1'b1;
                row_we   = 1'b1;
                if (5'(cnt_in) < ways_eff)
                begin
                    // Fill the first free way
                    valid_out[free_way] = 1'b1;
                    dirty_out[free_way] = 1'b0;
                    tag_out[free_way]   = tag;
                    rank_out[free_way]  = RK_W'(cnt_in);
                    cnt_out             = CN_W'(5'(cnt_in) + 5'd1);
                end
                else
                begin
                    // Evict the oldest way
                    if (valid_in[old_way] && dirty_in[old_way] && !cfg.write_through_mode)
                    begin
                        rsp.writeback         = 1'b1;
                        rsp.writeback_address =
                            (32'(tag_in[old_way]) << (INDEX_BITS + OFFSET_BITS))
                            | (32'(set_idx) << OFFSET_BITS);
                    end
                    tag_out[old_way]   = tag;
                    dirty_out[old_way] = 1'b0;
                    valid_out[old_way] = 1'b1;
                    mk_way             = old_way;
                    do_mk = (cfg.replace_policy == POL_LRU) || (cfg.replace_policy == POL_FIFO);
                end
            end
        end

        // Move the chosen way to the newest rank
        r   = rank_in[mk_way];
        top = '0;
        if (do_mk)
        begin
            for (int w = 0; w < MAX_WAYS; w++)
            begin
                if (valid_out[w])
                begin
                    if (rank_in[w] > r)
                        rank_out[w] = rank_in[w] - RK_W'(1);
                    top = top + 5'd1;
                end
            end
            rank_out[mk_way] = RK_W'(top - 5'd1);
        end
    end

endmodule

// ----- hdl/set_assoc_cache_tag_controller.sv -----
// Set-associative cache tag controller: top level with config registers and control.
// Depends on sact_pkg, sact_mem, sact_upd.
//
// Each accepted item is a cache access; the result item reports hit, block
// crossing, lower-level access, fill and dirty-victim writeback. For each item
// the set's metadata row is read from a synchronous memory with one read and
// one write port in the accept cycle, then updated and written back in the
// update state once the result register is empty or being taken; no new item is
// accepted until then. After reset a clearing pass writes every set row, during
// which no item is accepted; configuration writes are taken at any time.
module set_assoc_cache_tag_controller #(
    parameter int INDEX_BITS  = 6,
    parameter int OFFSET_BITS = 6,
    parameter int MAX_WAYS    = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  sact_pkg::req_t      in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output sact_pkg::rsp_t      out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import sact_pkg::*;

    localparam int NUM_SETS = 1 << INDEX_BITS;
    localparam int SI_W  = (INDEX_BITS > 0) ? INDEX_BITS : 1;
    localparam int TAG_W = 32 - INDEX_BITS - OFFSET_BITS;
    localparam int RK_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int CN_W  = $clog2(MAX_WAYS + 1);
    localparam int ROW_W = MAX_WAYS * (TAG_W + RK_W + 2) + CN_W;

    typedef enum logic [1:0] { S_CLEAR, S_IDLE, S_UPD } state_t;

    state_t          state_reg;
    logic [SI_W-1:0] clr_reg;
    cfg_t            cfg_reg;
    req_t            req_reg;
    logic            out_valid_reg;
    logic            out_valid_next;
    rsp_t            out_reg;

    logic [MAX_WAYS-1:0][TAG_W-1:0] tag_in, tag_out;
    logic [MAX_WAYS-1:0][RK_W-1:0]  rank_in, rank_out;
    logic [MAX_WAYS-1:0]            valid_in, valid_out, dirty_in, dirty_out;
    logic [CN_W-1:0]                cnt_in, cnt_out;
    logic                           row_we;
    rsp_t                           rsp;

    logic [ROW_W-1:0] rdata, wdata;
    logic [SI_W-1:0]  set_idx, rd_set, waddr;
    logic             accept, advance, we;
    logic             cfg_wr;

    assign accept  = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);
    assign advance = (state_reg == S_UPD) && (!out_valid_reg || !out_stall);
    assign set_idx = SI_W'((req_reg.address >> OFFSET_BITS) & 32'(NUM_SETS - 1));
    assign rd_set  = SI_W'((in_data.address >> OFFSET_BITS) & 32'(NUM_SETS - 1));

    assign {cnt_in, rank_in, dirty_in, valid_in, tag_in} = rdata;

    // Write back the updated row, or zeros while clearing
    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            we    = 1'b1;
            waddr = clr_reg;
            wdata = '0;
        end
        else
        begin
            we    = advance && row_we;
            waddr = set_idx;
            wdata = {cnt_out, rank_out, dirty_out, valid_out, tag_out};
        end
    end

    sact_mem #(
        .DEPTH  (NUM_SETS),
        .ADDR_W (SI_W),
        .DATA_W (ROW_W)
    ) u_mem (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (accept),
        .raddr (rd_set),
        .rdata (rdata)
    );

    sact_upd #(
        .INDEX_BITS  (INDEX_BITS),
        .OFFSET_BITS (OFFSET_BITS),
        .MAX_WAYS    (MAX_WAYS),
        .TAG_W       (TAG_W),
        .RK_W        (RK_W),
        .CN_W        (CN_W),
        .SI_W        (SI_W)
    ) u_upd (
        .req       (req_reg),
        .cfg       (cfg_reg),
        .set_idx   (set_idx),
        .tag_in    (tag_in),
        .rank_in   (rank_in),
        .valid_in  (valid_in),
        .dirty_in  (dirty_in),
        .cnt_in    (cnt_in),
        .tag_out   (tag_out),
        .rank_out  (rank_out),
        .valid_out (valid_out),
        .dirty_out (dirty_out),
        .cnt_out   (cnt_out),
        .row_we    (row_we),
        .rsp       (rsp)
    );

    // Drop the result item once taken, raise it when a new one is ready
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (advance)
            out_valid_next = 1'b1;
    end

    // Sequence clear, accept and update; hold the result item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + SI_W'(1);
                    if (clr_reg == SI_W'(NUM_SETS - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (accept)
                        state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    if (advance)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Capture payloads
    always_ff @(posedge clk)
    begin
        if (accept)
            req_reg <= in_data;
        if (advance)
            out_reg <= rsp;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Configuration registers
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ways_in_use         <= 4'd8;
            cfg_reg.write_through_mode  <= 1'b0;
            cfg_reg.write_allocate_mode <= 1'b1;
            cfg_reg.replace_policy      <= POL_LRU;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_WAYS: cfg_reg.ways_in_use         <= pwdata[3:0];
                REG_WT:   cfg_reg.write_through_mode  <= pwdata[0];
                REG_WA:   cfg_reg.write_allocate_mode <= pwdata[0];
                REG_POL:  cfg_reg.replace_policy      <= pwdata[1:0];
                default:  ;
            endcase
        end
    end

    // Register read back
    always_comb
    begin
        case (paddr[3:2])
            REG_WAYS: prdata = 32'(cfg_reg.ways_in_use);
            REG_WT:   prdata = 32'(cfg_reg.write_through_mode);
            REG_WA:   prdata = 32'(cfg_reg.write_allocate_mode);
            REG_POL:  prdata = 32'(cfg_reg.replace_policy);
            default:  prdata = '0;
        endcase
    end

endmodule
